### rtl/pcbp_pkg.sv
// Package: widths, table geometry, memory port types and the table address map.
`timescale 1ns / 1ps

package pcbp_pkg;

   localparam int MaxAmount  = 256;
   localparam int TableSide  = MaxAmount + 1;
   localparam int TableSize  = TableSide * TableSide;
   localparam int AddrWidth  = $clog2(TableSize);
   localparam int FieldWidth = 9;
   localparam int CountWidth = 64;

   typedef logic [FieldWidth-1:0] field_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [AddrWidth-1:0]  addr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } rd_req_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      count_type data;
   } wr_req_type;

   // Row-major entry (m,k) of the count table.
   function automatic addr_type table_addr(input field_type m, input field_type k);
      return AddrWidth'(m * TableSide + k);
   endfunction

endpackage

### rtl/pcbp_ifs.sv
// Interfaces: query request channel and count response channel.
`timescale 1ns / 1ps

interface pcbp_req_if import pcbp_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type amount;
   field_type min_parts;
   field_type max_parts;

   modport source (output valid, output amount, output min_parts, output max_parts,
                   input ready);
   modport sink   (input valid, input amount, input min_parts, input max_parts,
                   output ready);
endinterface

interface pcbp_rsp_if import pcbp_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type partition_count;

   modport source (output valid, output partition_count, input ready);
   modport sink   (input valid, input partition_count, output ready);
endinterface

### rtl/pcbp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pcbp_ram #(
   parameter int Width = 64,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pcbp_fill.sv
// Table builder: sweeps (m,k) once after reset, one entry per cycle, two-stage pipe.
`timescale 1ns / 1ps

module pcbp_fill import pcbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   output rd_req_type rd_req,
   input  count_type  rd_data,
   output wr_req_type wr_req,
   output logic       table_ready
);

   field_type m_ff, m_in;
   field_type k_ff, k_in;
   logic      run_ff, run_in;
   logic      done_ff, done_in;

   // second stage: entry being written
   logic      s1_valid_ff;
   addr_type  s1_addr_ff;
   logic      s1_use_ff;
   logic      s1_first_ff;
   logic      s1_one_ff;
   count_type prev_ff, prev_in;

   logic      use_upper;
   logic      last_col;
   count_type new_value;

   always_comb begin
      use_upper = (k_ff != '0) && (m_ff >= k_ff);
      last_col  = (k_ff == FieldWidth'(MaxAmount));
      m_in   = m_ff;
      k_in   = k_ff;
      run_in = run_ff;
      if (run_ff) begin
         if (last_col) begin
            k_in = '0;
            m_in = m_ff + 1'b1;
            if (m_ff == FieldWidth'(MaxAmount)) begin
               run_in = 1'b0;
            end
         end else begin
            k_in = k_ff + 1'b1;
         end
      end

      // T(m,k) = T(m,k-1) + T(m-k,k); row m-k is already complete
      if (s1_first_ff) begin
         new_value = s1_one_ff ? CountWidth'(1) : '0;
      end else begin
         new_value = prev_ff + (s1_use_ff ? rd_data : '0);
      end
      prev_in = s1_valid_ff ? new_value : prev_ff;
      done_in = done_ff || (s1_valid_ff && !run_ff);

      rd_req.en   = run_ff && use_upper;
      rd_req.addr = table_addr(m_ff - k_ff, k_ff);
      wr_req.en   = s1_valid_ff;
      wr_req.addr = s1_addr_ff;
      wr_req.data = new_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff        <= '0;
         k_ff        <= '0;
         run_ff      <= 1'b1;
         done_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         m_ff        <= m_in;
         k_ff        <= k_in;
         run_ff      <= run_in;
         done_ff     <= done_in;
         s1_valid_ff <= run_ff;
      end
      s1_addr_ff  <= table_addr(m_ff, k_ff);
      s1_use_ff   <= use_upper;
      s1_first_ff <= (k_ff == '0);
      s1_one_ff   <= (m_ff == '0);
      prev_ff     <= prev_in;
   end

   assign table_ready = done_ff;

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff) else $error("table ready flag dropped");
   a_no_write_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !wr_req.en && !run_ff) else $error("fill activity after table ready");
   a_read_only_while_running: assert property (@(posedge clock) disable iff (reset)
      rd_req.en |-> run_ff && (k_ff != '0)) else $error("builder read outside the sweep");

endmodule

### rtl/pcbp_query.sv
// Query engine: two table reads per query, subtract, hold result in output register.
`timescale 1ns / 1ps

module pcbp_query import pcbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              table_ready,
   pcbp_req_if.sink          req_bus,
   pcbp_rsp_if.source        rsp_bus,
   output rd_req_type        rd_req,
   input  count_type         rd_data
);

   localparam logic StIdle   = 1'b0;
   localparam logic StSecond = 1'b1;

   logic      state_ff, state_in;
   field_type amount_ff;
   field_type lo_ff;
   logic      ok_ff;
   logic      lat1_ff;
   logic      fin_ff;
   count_type data1_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   count_type rsp_data_ff;

   logic      accept;
   logic      go_second;
   field_type hi_clamp;
   logic      range_ok;
   count_type result;

   always_comb begin
      hi_clamp = (req_bus.max_parts > req_bus.amount) ? req_bus.amount : req_bus.max_parts;
      range_ok = (req_bus.amount <= FieldWidth'(MaxAmount)) &&
                 (req_bus.min_parts <= hi_clamp);

      req_bus.ready = table_ready && (state_ff == StIdle);
      accept        = req_bus.valid && req_bus.ready;
      // advance only when the output register will be free to take the result via fin_ff
      go_second     = (state_ff == StSecond) && (!rsp_valid_ff || rsp_bus.ready);

      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StSecond;
            end
         end
         StSecond: begin
            if (go_second) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase

      rd_req.en = accept || go_second;
      if (accept) begin
         rd_req.addr = range_ok ? table_addr(req_bus.amount, hi_clamp) : '0;
      end else begin
         rd_req.addr = (ok_ff && lo_ff != '0) ? table_addr(amount_ff, lo_ff - 1'b1) : '0;
      end

      if (!ok_ff) begin
         result = '0;
      end else if (lo_ff != '0) begin
         result = data1_ff - rd_data;
      end else begin
         result = data1_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fin_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         lat1_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lat1_ff      <= accept;
         fin_ff       <= go_second;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         amount_ff <= req_bus.amount;
         lo_ff     <= req_bus.min_parts;
         ok_ff     <= range_ok;
      end
      if (lat1_ff) begin
         data1_ff <= rd_data;
      end
      if (fin_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.partition_count = rsp_data_ff;

   a_accept_after_fill: assert property (@(posedge clock) disable iff (reset)
      accept |-> table_ready) else $error("query taken before table filled");
   a_slot_free_on_finish: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !rsp_valid_ff) else $error("result would overwrite pending beat");
   a_accept_to_second: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == StSecond) && lat1_ff) else $error("second read not scheduled");

endmodule

### rtl/partition_count_bounded_parts_top.sv
// Top level: bounded-part partition counter built around one count-table RAM.
//
//  channel  | dir | handshake         | payload
//  req_bus  | in  | valid/ready       | amount, min_parts, max_parts (9 b each)
//  rsp_bus  | out | valid/ready       | partition_count (64 b)
//
//  After reset the table is built one entry per cycle; req_bus.ready first
//  rises once the last entry is written. A query then makes two reads
//  through the RAM's single read port. The first read is held in data1_ff;
//  the result is loaded into the output register when fin_ff is set.
//  A stalled response holds the engine in its second-read step; the next
//  request beat can be taken in the cycle after that read issues.
`timescale 1ns / 1ps

module partition_count_bounded_parts_top import pcbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pcbp_req_if.sink   req_bus,
   pcbp_rsp_if.source rsp_bus
);

   rd_req_type fill_rd;
   rd_req_type query_rd;
   rd_req_type ram_rd;
   wr_req_type fill_wr;
   count_type  ram_rdata;
   logic       table_ready;

   pcbp_fill u_fill (
      .clock       (clock),
      .reset       (reset),
      .rd_req      (fill_rd),
      .rd_data     (ram_rdata),
      .wr_req      (fill_wr),
      .table_ready (table_ready)
   );

   pcbp_query u_query (
      .clock       (clock),
      .reset       (reset),
      .table_ready (table_ready),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .rd_req      (query_rd),
      .rd_data     (ram_rdata)
   );

   // read port belongs to the builder until the table is complete
   assign ram_rd = table_ready ? query_rd : fill_rd;

   pcbp_ram #(
      .Width (CountWidth),
      .Depth (TableSize)
   ) u_table (
      .clock   (clock),
      .wr_en   (fill_wr.en),
      .wr_addr (fill_wr.addr),
      .wr_data (fill_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rdata)
   );

endmodule
